FILE: hw/rtl/height_grid_window_range_defines.svh
// Assertion macros shared by the height grid window range RTL.
`ifndef HEIGHT_GRID_WINDOW_RANGE_DEFINES_SVH
`define HEIGHT_GRID_WINDOW_RANGE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HGWR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hgwr assertion failed");

// Next-cycle implication, disabled during reset.
`define HGWR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hgwr assertion failed");

`endif

FILE: hw/rtl/hgwr_pkg.sv
// Shared types and constants for the height grid window range block.
package hgwr_pkg;

  localparam int GRID_SIDE_DEF   = 128;
  localparam int HEIGHT_BITS_DEF = 16;
  localparam int HALF_WINDOW     = 4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_GRID_MAX    = 1'b0;
  localparam logic REG_RANGE_LIMIT = 1'b1;

  localparam logic [6:0]  GRID_MAX_RESET    = 7'd100;
  localparam logic [15:0] RANGE_LIMIT_RESET = 16'd492;
  localparam logic [15:0] RANGE_MAX         = 16'hFFFF;

  typedef struct packed {
    logic               command;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [15:0] height;
  } request_t;

  typedef struct packed {
    logic [6:0]  out_row;
    logic [6:0]  out_col;
    logic [15:0] height_range;
    logic        passable;
    logic        valid_res;
  } result_t;

endpackage

FILE: hw/rtl/hgwr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module hgwr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/height_grid_window_range.sv
// Top level: terrain height grid with windowed max-minus-min range queries.
//
//  channel   handshake                  payload
//  request   start in, busy out         request (request_t)
//  result    done strobe out            result (result_t)
//  config    APB psel/penable/pready    paddr, pwdata, prdata
//
// A write request leaves busy low and no result follows. A query inside the
// grid keeps busy high while it scans the N cells of the clipped window (at
// most 81), then through a drain and a done state; the single grid RAM read
// port fetches one cell per cycle. The done strobe rises at the edge where busy
// falls. A query beyond the grid skips the scan and goes straight to done. Reset
// is synchronous and leaves the grid contents undefined; the receiver cannot stall results.
`include "height_grid_window_range_defines.svh"

module height_grid_window_range
  import hgwr_pkg::*;
#(
  parameter int GRID_SIDE   = GRID_SIDE_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  request_t    request,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(GRID_SIDE);
  localparam int CW    = ((IDX_W > 7) ? IDX_W : 7) + 1;
  localparam int AW    = 2 * IDX_W;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = HEIGHT_BITS + 1;
  localparam int SW    = (DW > 17) ? DW : 17;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_t;

  state_t state;

  logic [6:0]  grid_max_index;
  logic [15:0] range_limit;

  logic [IDX_W-1:0] r, c, lo_c, hi_r, hi_c;
  logic [6:0]       q_row, q_col;
  logic             q_valid;
  logic             rd_pend;
  logic             first;

  logic signed [HEIGHT_BITS-1:0] mx, mn, h_rd;
  logic [HEIGHT_BITS-1:0]        rd_data;

  logic [CW-1:0] row_ext, col_ext, lim, hi_r_ext, hi_c_ext, lo_r_ext, lo_c_ext;
  logic          in_grid, in_mem, wr_en, req_acc;
  logic [DW-1:0] diff;
  logic [SW-1:0] diff_ext;
  logic [15:0]   range_sat;
  result_t       res_next;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_max_index <= GRID_MAX_RESET;
      range_limit    <= RANGE_LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_GRID_MAX:    grid_max_index <= pwdata[6:0];
        REG_RANGE_LIMIT: range_limit    <= pwdata[15:0];
        default:         grid_max_index <= grid_max_index;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRID_MAX:    prdata = 32'(grid_max_index);
      REG_RANGE_LIMIT: prdata = 32'(range_limit);
      default:         prdata = '0;
    endcase
  end

  // Window bounds and request decode
  always_comb begin
    row_ext = CW'(request.row);
    col_ext = CW'(request.col);
    lim = (CW'(grid_max_index) > CW'(GRID_SIDE - 1)) ? CW'(GRID_SIDE - 1)
                                                     : CW'(grid_max_index);
    in_grid  = (row_ext <= lim) && (col_ext <= lim);
    in_mem   = (row_ext < CW'(GRID_SIDE)) && (col_ext < CW'(GRID_SIDE));
    lo_r_ext = (row_ext >= CW'(HALF_WINDOW)) ? row_ext - CW'(HALF_WINDOW) : '0;
    lo_c_ext = (col_ext >= CW'(HALF_WINDOW)) ? col_ext - CW'(HALF_WINDOW) : '0;
    hi_r_ext = row_ext + CW'(HALF_WINDOW);
    hi_c_ext = col_ext + CW'(HALF_WINDOW);
    if (hi_r_ext > lim) begin
      hi_r_ext = lim;
    end
    if (hi_c_ext > lim) begin
      hi_c_ext = lim;
    end
  end

  assign busy    = (state != ST_IDLE);
  assign req_acc = start && !busy;
  assign wr_en   = req_acc && (request.command == CMD_WRITE) && in_mem;

  hgwr_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (wr_en),
    .waddr ({row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]}),
    .wdata (HEIGHT_BITS'(request.height)),
    .re    (state == ST_SCAN),
    .raddr ({r, c}),
    .rdata (rd_data)
  );

  assign h_rd = rd_data;

  // Range, saturation and pass decision
  always_comb begin
    diff      = {mx[HEIGHT_BITS-1], mx} - {mn[HEIGHT_BITS-1], mn};
    diff_ext  = SW'(diff);
    range_sat = (diff_ext > SW'(RANGE_MAX)) ? RANGE_MAX : diff_ext[15:0];
    res_next.out_row = q_row;
    res_next.out_col = q_col;
    if (q_valid) begin
      res_next.height_range = range_sat;
      res_next.passable     = (range_sat < range_limit);
      res_next.valid_res    = 1'b1;
    end else begin
      res_next.height_range = '0;
      res_next.passable     = 1'b0;
      res_next.valid_res    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      done    <= (state == ST_DONE);
      rd_pend <= (state == ST_SCAN);
      unique case (state)
        ST_IDLE: begin
          if (start && request.command == CMD_QUERY) begin
            q_row   <= request.row;
            q_col   <= request.col;
            q_valid <= in_grid;
            r       <= lo_r_ext[IDX_W-1:0];
            c       <= lo_c_ext[IDX_W-1:0];
            lo_c    <= lo_c_ext[IDX_W-1:0];
            hi_r    <= hi_r_ext[IDX_W-1:0];
            hi_c    <= hi_c_ext[IDX_W-1:0];
            first   <= 1'b1;
            state   <= in_grid ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          if (c == hi_c) begin
            c <= lo_c;
            if (r == hi_r) begin
              state <= ST_DRAIN;
            end else begin
              r <= r + 1'b1;
            end
          end else begin
            c <= c + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          result <= res_next;
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // Read data lands in the cycle after its address; fold it into max and min.
      if (rd_pend) begin
        first <= 1'b0;
        if (first || h_rd > mx) begin
          mx <= h_rd;
        end
        if (first || h_rd < mn) begin
          mn <= h_rd;
        end
      end
    end
  end

  `HGWR_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `HGWR_ASSERT_NEXT(a_query_busy, clk, rst, req_acc && request.command == CMD_QUERY, busy)
  `HGWR_ASSERT_NEXT(a_write_quiet, clk, rst, req_acc && request.command == CMD_WRITE, !busy && !done)
  `HGWR_ASSERT_NOW(a_drain_pend, clk, rst, state == ST_DRAIN, rd_pend)
  `HGWR_ASSERT_NOW(a_scan_window, clk, rst, state == ST_SCAN, r <= hi_r && c <= hi_c)

endmodule
